// File: design/prrts_pkg.sv
// shared types, constants and codes for the task scheduler
`timescale 1ns / 1ps

package prrts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [7:0] IDLE_PRIO = 8'd255;

    typedef enum logic [2:0] {
        FN_CREATE = 3'd0,
        FN_TICK   = 3'd1,
        FN_DELAY  = 3'd2,
        FN_SWITCH = 3'd3,
        FN_START  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_FULL     = 2'd1,
        RES_NO_TASKS = 2'd2,
        RES_IGNORED  = 2'd3
    } status_t;

    localparam logic [1:0] RS_READY   = 2'd0;
    localparam logic [1:0] RS_RUNNING = 2'd1;
    localparam logic [1:0] RS_BLOCKED = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CREATE,
        OP_TICK,
        OP_DELAY,
        OP_DEMOTE,
        OP_RUN
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  target;
        logic [7:0]        prio;
        logic [31:0]       sp;
        logic [31:0]       ticks;
        logic [IDX_W-1:0]  cur;
        logic [CNT_W-1:0]  count;
    } cell_cmd_t;

    typedef struct packed {
        logic              found;
        logic [7:0]        prio;
        logic [CNT_W-1:0]  gap;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       sp;
    } cand_t;

endpackage

// File: design/prrts_cell.sv
// one task table entry with its stage of the candidate chain
`timescale 1ns / 1ps

module prrts_cell (
    input  logic                            clk,
    input  logic [prrts_pkg::IDX_W-1:0]     cell_idx,
    input  prrts_pkg::cell_cmd_t            cmd,
    input  prrts_pkg::cand_t                cand_in,
    output prrts_pkg::cand_t                cand_out
);

    logic [1:0]  run_state_reg, run_state_next;
    logic [7:0]  prio_reg, prio_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [31:0] sp_reg, sp_next;
    prrts_pkg::cand_t cand_reg, cand_next;

    logic                        hit;
    logic                        in_table;
    logic                        eligible;
    logic                        take;
    logic [prrts_pkg::CNT_W-1:0] idx_ext;
    logic [prrts_pkg::CNT_W-1:0] cur_ext;
    logic [prrts_pkg::CNT_W-1:0] gap;

    // entry update
    always_comb
    begin
        hit            = (cmd.target == cell_idx);
        idx_ext        = prrts_pkg::CNT_W'(cell_idx);
        in_table       = (idx_ext < cmd.count);
        run_state_next = run_state_reg;
        prio_next      = prio_reg;
        ticks_next     = ticks_reg;
        sp_next        = sp_reg;
        unique case (cmd.op)
            prrts_pkg::OP_CREATE:
            begin
                if (hit)
                begin
                    run_state_next = prrts_pkg::RS_READY;
                    prio_next      = cmd.prio;
                    ticks_next     = '0;
                    sp_next        = cmd.sp;
                end
            end
            prrts_pkg::OP_TICK:
            begin
                if ((cell_idx != '0) && in_table &&
                    (run_state_reg == prrts_pkg::RS_BLOCKED) && (ticks_reg != '0))
                begin
                    ticks_next = ticks_reg - 32'd1;
                    if (ticks_reg == 32'd1)
                    begin
                        run_state_next = prrts_pkg::RS_READY;
                    end
                end
            end
            prrts_pkg::OP_DELAY:
            begin
                if (hit)
                begin
                    ticks_next     = cmd.ticks;
                    run_state_next = prrts_pkg::RS_BLOCKED;
                end
            end
            prrts_pkg::OP_DEMOTE:
            begin
                if (hit)
                begin
                    sp_next = cmd.sp;
                    if (run_state_reg == prrts_pkg::RS_RUNNING)
                    begin
                        run_state_next = prrts_pkg::RS_READY;
                    end
                end
            end
            prrts_pkg::OP_RUN:
            begin
                if (hit)
                begin
                    run_state_next = prrts_pkg::RS_RUNNING;
                end
            end
            default:
            begin
            end
        endcase
    end

    // candidate stage: keep the better of the incoming and this entry
    always_comb
    begin
        cur_ext = prrts_pkg::CNT_W'(cmd.cur);
        if (idx_ext > cur_ext)
        begin
            gap = idx_ext - cur_ext - prrts_pkg::CNT_W'(1);
        end
        else
        begin
            gap = idx_ext + cmd.count - cur_ext - prrts_pkg::CNT_W'(1);
        end
        eligible = in_table && (prio_reg != prrts_pkg::IDLE_PRIO) &&
                   ((run_state_reg == prrts_pkg::RS_READY) ||
                    (run_state_reg == prrts_pkg::RS_RUNNING));
        take = eligible && (!cand_in.found || (prio_reg < cand_in.prio) ||
                            ((prio_reg == cand_in.prio) && (gap < cand_in.gap)));
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found = 1'b1;
            cand_next.prio  = prio_reg;
            cand_next.gap   = gap;
            cand_next.idx   = cell_idx;
            cand_next.sp    = sp_reg;
        end
        else if (!cand_in.found && (cell_idx == '0))
        begin
            // idle fallback carries entry zero's stack pointer
            cand_next.sp = sp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        run_state_reg <= run_state_next;
        prio_reg      <= prio_next;
        ticks_reg     <= ticks_next;
        sp_reg        <= sp_next;
        cand_reg      <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

// File: design/prrts_ctrl.sv
// sequencer, scheduler registers and result register
`timescale 1ns / 1ps

module prrts_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   func,
    input  logic [7:0]                   priority_req,
    input  logic [31:0]                  stack_pointer,
    input  logic [31:0]                  delay_ticks,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [3:0]                   task_index,
    output logic [31:0]                  task_sp,
    output logic                         switch_request,
    output prrts_pkg::cell_cmd_t         cmd,
    input  prrts_pkg::cand_t             cand
);

    prrts_pkg::state_t  state_reg, state_next;
    prrts_pkg::func_t   func_reg, func_next;
    logic [7:0]         prio_reg, prio_next;
    logic [31:0]        sp_reg, sp_next;
    logic [31:0]        dly_reg, dly_next;
    logic [prrts_pkg::CNT_W-1:0] count_reg, count_next;
    logic [prrts_pkg::IDX_W-1:0] cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    logic               running_reg, running_next;
    logic [prrts_pkg::IDX_W-1:0] scan_cnt_reg, scan_cnt_next;

    logic               out_valid_reg, out_valid_next;
    prrts_pkg::status_t status_reg, status_next;
    logic [3:0]         index_reg, index_next;
    logic [31:0]        tsp_reg, tsp_next;
    logic               req_reg, req_next;

    logic               out_free;
    logic               load_out;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prrts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = prrts_pkg::S_EXEC;
                end
            end
            prrts_pkg::S_EXEC:
            begin
                if ((func_reg == prrts_pkg::FN_SWITCH) && (count_reg != '0))
                begin
                    state_next = prrts_pkg::S_SCAN;
                end
                else if (out_free)
                begin
                    state_next = prrts_pkg::S_IDLE;
                end
            end
            prrts_pkg::S_SCAN:
            begin
                if (scan_cnt_reg == '0)
                begin
                    state_next = prrts_pkg::S_FINISH;
                end
            end
            prrts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = prrts_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == prrts_pkg::S_IDLE);
        func_next      = func_reg;
        prio_next      = prio_reg;
        sp_next        = sp_reg;
        dly_next       = dly_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        running_next   = running_reg;
        scan_cnt_next  = scan_cnt_reg;
        load_out       = 1'b0;
        status_next    = status_reg;
        index_next     = index_reg;
        tsp_next       = tsp_reg;
        req_next       = req_reg;

        cmd        = '0;
        cmd.op     = prrts_pkg::OP_NONE;
        cmd.cur    = cur_reg;
        cmd.count  = count_reg;

        unique case (state_reg)
            prrts_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = prrts_pkg::func_t'(func);
                    prio_next = priority_req;
                    sp_next   = stack_pointer;
                    dly_next  = delay_ticks;
                end
            end
            prrts_pkg::S_EXEC:
            begin
                status_next = prrts_pkg::RES_OK;
                index_next  = '0;
                tsp_next    = '0;
                req_next    = 1'b0;
                unique case (func_reg)
                    prrts_pkg::FN_CREATE:
                    begin
                        load_out = out_free;
                        if (count_reg >= prrts_pkg::CNT_W'(prrts_pkg::MAX_TASKS))
                        begin
                            status_next = prrts_pkg::RES_FULL;
                        end
                        else
                        begin
                            index_next = 4'(count_reg[prrts_pkg::IDX_W-1:0]);
                            if (out_free)
                            begin
                                cmd.op     = prrts_pkg::OP_CREATE;
                                cmd.target = count_reg[prrts_pkg::IDX_W-1:0];
                                cmd.prio   = prio_reg;
                                cmd.sp     = sp_reg;
                                count_next = count_reg + prrts_pkg::CNT_W'(1);
                            end
                        end
                    end
                    prrts_pkg::FN_TICK:
                    begin
                        load_out = out_free;
                        if (out_free)
                        begin
                            cmd.op = prrts_pkg::OP_TICK;
                        end
                    end
                    prrts_pkg::FN_DELAY:
                    begin
                        load_out = out_free;
                        if (cur_valid_reg && (dly_reg != '0))
                        begin
                            req_next = running_reg;
                            if (out_free)
                            begin
                                cmd.op     = prrts_pkg::OP_DELAY;
                                cmd.target = cur_reg;
                                cmd.ticks  = dly_reg;
                            end
                        end
                        else
                        begin
                            status_next = prrts_pkg::RES_IGNORED;
                        end
                    end
                    prrts_pkg::FN_SWITCH:
                    begin
                        if (count_reg == '0)
                        begin
                            load_out    = out_free;
                            status_next = prrts_pkg::RES_NO_TASKS;
                        end
                        else
                        begin
                            // save outgoing sp before the sweep starts
                            if (cur_valid_reg)
                            begin
                                cmd.op     = prrts_pkg::OP_DEMOTE;
                                cmd.target = cur_reg;
                                cmd.sp     = sp_reg;
                            end
                            scan_cnt_next = prrts_pkg::IDX_W'(prrts_pkg::MAX_TASKS - 1);
                        end
                    end
                    prrts_pkg::FN_START:
                    begin
                        load_out = out_free;
                        if (count_reg == '0)
                        begin
                            status_next = prrts_pkg::RES_NO_TASKS;
                        end
                        else
                        begin
                            req_next = 1'b1;
                            if (out_free)
                            begin
                                running_next   = 1'b1;
                                cur_valid_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        load_out    = out_free;
                        status_next = prrts_pkg::RES_IGNORED;
                    end
                endcase
            end
            prrts_pkg::S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg - prrts_pkg::IDX_W'(1);
            end
            prrts_pkg::S_FINISH:
            begin
                load_out    = out_free;
                status_next = prrts_pkg::RES_OK;
                index_next  = 4'(cand.idx);
                tsp_next    = cand.sp;
                req_next    = 1'b0;
                if (out_free)
                begin
                    cmd.op         = prrts_pkg::OP_RUN;
                    cmd.target     = cand.idx;
                    cur_next       = cand.idx;
                    cur_valid_next = 1'b1;
                end
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prrts_pkg::S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            running_reg   <= running_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        prio_reg <= prio_next;
        sp_reg   <= sp_next;
        dly_reg  <= dly_next;
        if (load_out)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            tsp_reg    <= tsp_next;
            req_reg    <= req_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign task_index     = index_reg;
    assign task_sp        = tsp_reg;
    assign switch_request = req_reg;

endmodule

// File: design/priority_round_robin_task_scheduler_core.sv
// top level of the priority round-robin task scheduler
`timescale 1ns / 1ps

// channel   handshake              payload
// in        in_valid / in_ready    func, priority_req, stack_pointer, delay_ticks
// out       out_valid / out_ready  status, task_index, task_sp, switch_request
//
// create, tick, delay, start and unused codes: done in the exec state, and a
// new request is taken only back in idle; switch adds the scan and finish states
// for the candidate sweep that moves one cell per cycle down the chain of task cells
// reset clears the task count, current task and run flag; table entries
// hold until written. a stalled result holds the sequencer before its commit

module priority_round_robin_task_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [7:0]  priority_req,
    input  logic [31:0] stack_pointer,
    input  logic [31:0] delay_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  task_index,
    output logic [31:0] task_sp,
    output logic        switch_request
);

    prrts_pkg::cell_cmd_t cmd;
    prrts_pkg::cand_t     cand_chain [0:prrts_pkg::MAX_TASKS];

    assign cand_chain[0] = '0;

    for (genvar k = 0; k < prrts_pkg::MAX_TASKS; k++)
    begin : g_cell
        prrts_cell u_cell (
            .clk      (clk),
            .cell_idx (prrts_pkg::IDX_W'(k)),
            .cmd      (cmd),
            .cand_in  (cand_chain[k]),
            .cand_out (cand_chain[k+1])
        );
    end

    prrts_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .priority_req   (priority_req),
        .stack_pointer  (stack_pointer),
        .delay_ticks    (delay_ticks),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .task_index     (task_index),
        .task_sp        (task_sp),
        .switch_request (switch_request),
        .cmd            (cmd),
        .cand           (cand_chain[prrts_pkg::MAX_TASKS])
    );

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // committing the chosen task always produces a result
    a_run_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == prrts_pkg::OP_RUN) |=> (out_valid && (status == prrts_pkg::RES_OK)))
        else $error("switch commit without result");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == prrts_pkg::RES_FULL)) |->
        ((task_index == 4'd0) && (task_sp == 32'd0) && !switch_request))
        else $error("table full result carries data");

    a_no_tasks_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == prrts_pkg::RES_NO_TASKS)) |->
        ((task_index == 4'd0) && (task_sp == 32'd0)))
        else $error("no tasks result carries data");

endmodule

// File: tb/sv/tb.sv
// testbench for the task scheduler core: directed and random requests checked by a scoreboard
`timescale 1ns / 1ps

module tb;

    localparam int          CYCLE_LIMIT    = 300000;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          RANDOM_ITEMS   = 90;
    localparam logic [2:0]  FN_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  FN_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  index;
        logic [31:0] sp;
        logic        req;
    } sched_result_t;

    class sched_scoreboard;
        logic [1:0]    run_state [prrts_pkg::MAX_TASKS];
        logic [7:0]    prio_tab  [prrts_pkg::MAX_TASKS];
        logic [31:0]   wait_tab  [prrts_pkg::MAX_TASKS];
        logic [31:0]   sp_tab    [prrts_pkg::MAX_TASKS];
        int            task_count;
        int            cur_index;
        bit            cur_valid;
        bit            os_running;
        sched_result_t pending [$];
        int            mismatches;
        int            checked;
        int            op_count [8];
        int            full_rejects;
        int            fallbacks;

        function void note_request(logic [2:0] fn, logic [7:0] prio, logic [31:0] sp,
                                   logic [31:0] dly);
            sched_result_t r;
            int            best;
            int            idx;
            logic [7:0]    best_prio;
            r.status = prrts_pkg::RES_OK;
            r.index  = 4'd0;
            r.sp     = 32'd0;
            r.req    = 1'b0;
            op_count[fn]++;
            case (fn)
                prrts_pkg::FN_CREATE:
                begin
                    if (task_count >= prrts_pkg::MAX_TASKS)
                    begin
                        r.status = prrts_pkg::RES_FULL;
                        full_rejects++;
                    end
                    else
                    begin
                        run_state[task_count] = prrts_pkg::RS_READY;
                        prio_tab[task_count]  = prio;
                        wait_tab[task_count]  = 32'd0;
                        sp_tab[task_count]    = sp;
                        r.index = 4'(task_count);
                        task_count++;
                    end
                end
                prrts_pkg::FN_TICK:
                begin
                    for (int i = 1; i < task_count; i++)
                    begin
                        if (run_state[i] == prrts_pkg::RS_BLOCKED && wait_tab[i] != 32'd0)
                        begin
                            wait_tab[i]--;
                            if (wait_tab[i] == 32'd0)
                                run_state[i] = prrts_pkg::RS_READY;
                        end
                    end
                end
                prrts_pkg::FN_DELAY:
                begin
                    if (cur_valid && dly != 32'd0)
                    begin
                        wait_tab[cur_index]  = dly;
                        run_state[cur_index] = prrts_pkg::RS_BLOCKED;
                        r.req = os_running;
                    end
                    else
                        r.status = prrts_pkg::RES_IGNORED;
                end
                prrts_pkg::FN_SWITCH:
                begin
                    if (task_count == 0)
                        r.status = prrts_pkg::RES_NO_TASKS;
                    else
                    begin
                        if (cur_valid)
                        begin
                            sp_tab[cur_index] = sp;
                            if (run_state[cur_index] == prrts_pkg::RS_RUNNING)
                                run_state[cur_index] = prrts_pkg::RS_READY;
                        end
                        best      = 0;
                        best_prio = prrts_pkg::IDLE_PRIO;
                        // round-robin scan starting just past the current task
                        for (int i = 1; i <= task_count; i++)
                        begin
                            idx = (cur_index + i) % task_count;
                            if ((run_state[idx] == prrts_pkg::RS_READY ||
                                 run_state[idx] == prrts_pkg::RS_RUNNING)
                                && prio_tab[idx] < best_prio)
                            begin
                                best_prio = prio_tab[idx];
                                best      = idx;
                            end
                        end
                        if (best_prio == prrts_pkg::IDLE_PRIO)
                            fallbacks++;
                        cur_index       = best;
                        cur_valid       = 1'b1;
                        run_state[best] = prrts_pkg::RS_RUNNING;
                        r.index = 4'(best);
                        r.sp    = sp_tab[best];
                    end
                end
                prrts_pkg::FN_START:
                begin
                    if (task_count == 0)
                        r.status = prrts_pkg::RES_NO_TASKS;
                    else
                    begin
                        os_running = 1'b1;
                        cur_valid  = 1'b0;
                        r.req      = 1'b1;
                    end
                end
                default:
                    r.status = prrts_pkg::RES_IGNORED;
            endcase
            pending.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] exp_val, logic [31:0] got_val);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t on %s: expected %0h, got %0h",
                         $realtime, what, exp_val, got_val);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (pending.size() == 0)
            begin
                flag("unexpected result status", 32'd0, 32'(got.status));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status)
                flag("status", 32'(want.status), 32'(got.status));
            if (got.index !== want.index)
                flag("task_index", 32'(want.index), 32'(got.index));
            if (got.sp !== want.sp)
                flag("task_sp", want.sp, got.sp);
            if (got.req !== want.req)
                flag("switch_request", 32'(want.req), 32'(got.req));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [7:0]  priority_req;
    logic [31:0] stack_pointer;
    logic [31:0] delay_ticks;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [3:0]  task_index;
    logic [31:0] task_sp;
    logic        switch_request;

    int              idle_pct;
    int              stall_pct;
    int              cycle_count;
    sched_scoreboard sb;

    priority_round_robin_task_scheduler_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .priority_req   (priority_req),
        .stack_pointer  (stack_pointer),
        .delay_ticks    (delay_ticks),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .task_index     (task_index),
        .task_sp        (task_sp),
        .switch_request (switch_request)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        sched_result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(func, priority_req, stack_pointer, delay_ticks);
            if (out_valid && out_ready)
            begin
                got.status = status;
                got.index  = task_index;
                got.sp     = task_sp;
                got.req    = switch_request;
                sb.check_result(got);
            end
        end
    end

    task automatic send_request(logic [2:0] fn, logic [7:0] prio, logic [31:0] sp,
                                logic [31:0] dly);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            in_valid      <= 1'b0;
            func          <= 3'($urandom);
            priority_req  <= 8'($urandom);
            stack_pointer <= $urandom;
            delay_ticks   <= $urandom;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        func          <= fn;
        priority_req  <= prio;
        stack_pointer <= sp;
        delay_ticks   <= dly;
        // ready is stable between edges, so check it at the falling edge
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_random_request();
        int          roll;
        logic [2:0]  fn;
        logic [7:0]  prio;
        logic [31:0] dly;
        roll = $urandom_range(99);
        if (roll < 12)
            fn = prrts_pkg::FN_CREATE;
        else if (roll < 42)
            fn = prrts_pkg::FN_TICK;
        else if (roll < 60)
            fn = prrts_pkg::FN_DELAY;
        else if (roll < 88)
            fn = prrts_pkg::FN_SWITCH;
        else if (roll < 93)
            fn = prrts_pkg::FN_START;
        else
            fn = 3'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST));
        roll = $urandom_range(99);
        if (roll < 55)
            prio = 8'($urandom_range(3, 1));
        else if (roll < 70)
            prio = prrts_pkg::IDLE_PRIO;
        else
            prio = 8'($urandom_range(255));
        // mostly short delays so blocked tasks wake up again
        roll = $urandom_range(99);
        if (roll < 8)
            dly = 32'd0;
        else if (roll < 88)
            dly = $urandom_range(12, 1);
        else if (roll < 96)
            dly = $urandom_range(100, 13);
        else
            dly = $urandom;
        send_request(fn, prio, $urandom, dly);
    endtask

    initial
    begin
        int idle_set  [4];
        int stall_set [4];
        idle_set  = '{0, 73, 0, 33};
        stall_set = '{0, 0, 73, 33};
        sb            = new();
        idle_pct      = 0;
        stall_pct     = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = prrts_pkg::FN_TICK;
        priority_req  = 8'd0;
        stack_pointer = 32'd0;
        delay_ticks   = 32'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table and no current task
        send_request(prrts_pkg::FN_SWITCH, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(prrts_pkg::FN_START, 8'h00, 32'h0, 32'h0);
        send_request(prrts_pkg::FN_DELAY, 8'h00, 32'h0, 32'd5);
        send_request(prrts_pkg::FN_TICK, 8'h00, 32'h0, 32'h0);
        for (int c = FN_SPARE_FIRST; c <= FN_SPARE_LAST; c++)
            send_request(3'(c), 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // idle entry only, fallback pick
        send_request(prrts_pkg::FN_CREATE, prrts_pkg::IDLE_PRIO, 32'hA5A5_5A5A, 32'h0);
        send_request(prrts_pkg::FN_SWITCH, 8'h00, 32'h1234_5678, 32'h0);
        send_request(prrts_pkg::FN_DELAY, 8'h00, 32'h0, 32'd0);
        send_request(prrts_pkg::FN_DELAY, 8'h00, 32'h0, 32'hFFFF_FFFF);
        send_request(prrts_pkg::FN_CREATE, 8'd0, 32'hFFFF_FFFF, 32'h0);
        send_request(prrts_pkg::FN_CREATE, 8'd2, 32'h0000_1000, 32'h0);
        send_request(prrts_pkg::FN_CREATE, 8'd2, 32'h0000_2000, 32'h0);
        send_request(prrts_pkg::FN_SWITCH, 8'h00, 32'h0BAD_F00D, 32'h0);
        send_request(prrts_pkg::FN_START, 8'h00, 32'h0, 32'h0);
        send_request(prrts_pkg::FN_DELAY, 8'h00, 32'h0, 32'd3);
        send_request(prrts_pkg::FN_SWITCH, 8'h00, 32'h5A5A_A5A5, 32'h0);
        send_request(prrts_pkg::FN_DELAY, 8'h00, 32'h0, 32'd1);
        // equal priorities take turns
        send_request(prrts_pkg::FN_SWITCH, 8'h00, 32'h0000_0001, 32'h0);
        send_request(prrts_pkg::FN_SWITCH, 8'h00, 32'h8000_0000, 32'h0);
        send_request(prrts_pkg::FN_TICK, 8'h00, 32'h0, 32'h0);
        send_request(prrts_pkg::FN_SWITCH, 8'h00, 32'h7FFF_FFFF, 32'h0);
        send_request(prrts_pkg::FN_CREATE, 8'd254, 32'h0, 32'h0);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            for (int n = 0; n < RANDOM_ITEMS; n++)
                send_random_request();
            // a stretch with no idling between pressure phases
            idle_pct  = 0;
            stall_pct = 0;
            for (int n = 0; n < 8; n++)
                send_random_request();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d creates, %0d ticks, %0d delays, %0d switches, %0d starts",
                 sb.op_count[prrts_pkg::FN_CREATE], sb.op_count[prrts_pkg::FN_TICK],
                 sb.op_count[prrts_pkg::FN_DELAY], sb.op_count[prrts_pkg::FN_SWITCH],
                 sb.op_count[prrts_pkg::FN_START]);
        $display("%0d spare codes, %0d results checked, %0d tasks, %0d full-table creates, %0d idle fallbacks",
                 sb.op_count[5] + sb.op_count[6] + sb.op_count[7],
                 sb.checked, sb.task_count, sb.full_rejects, sb.fallbacks);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
